// ===== src/krts_pkg.sv =====
// Shared types and codes for the keyed record table.
package krts_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_SORT   = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_SORTED    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_ADD,
    CMD_SEARCH,
    CMD_SORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [15:0] copies;
  } cmd_t;

endpackage

// ===== src/krts_front.sv =====
// Front end: accepts input transfers and turns them into commands.
module krts_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // mode[1:0], key_char[9:2], copies_in[25:10]
  input  logic                s_axis_tlast,  // key_last
  output logic                cmd_valid,
  output krts_pkg::cmd_t      cmd,
  input  logic                cmd_ready
);

  logic                 keep;
  krts_pkg::cmd_t       cmd_next;
  logic [1:0]           mode;

  assign mode = s_axis_tdata[1:0];
  assign s_axis_tready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.ch     = s_axis_tdata[9:2];
    cmd_next.copies = s_axis_tdata[25:10];
    cmd_next.kind   = krts_pkg::CMD_CHAR;
    keep            = 1'b1;
    unique case (mode)
      krts_pkg::MODE_ADD: begin
        cmd_next.kind = s_axis_tlast ? krts_pkg::CMD_ADD : krts_pkg::CMD_CHAR;
      end
      krts_pkg::MODE_SEARCH: begin
        cmd_next.kind = s_axis_tlast ? krts_pkg::CMD_SEARCH : krts_pkg::CMD_CHAR;
      end
      krts_pkg::MODE_SORT: begin
        cmd_next.kind = krts_pkg::CMD_SORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      cmd_valid <= s_axis_tvalid && keep;
    end
    if (s_axis_tready && s_axis_tvalid && keep) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== src/krts_queue.sv =====
// Short command queue between front and back.
module krts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  krts_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output krts_pkg::cmd_t out_cmd
);

  localparam int PW = $clog2(krts_pkg::QUEUE_DEPTH);

  krts_pkg::cmd_t mem [krts_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    fill;
  logic           push;
  logic           pop;

  assign in_ready  = (fill != (PW+1)'(krts_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
    if (push) mem[wr_ptr] <= in_cmd;
  end

endmodule

// ===== src/krts_back.sv =====
// Back end: pending key, record store, add, search and bubble sort.
module krts_back #(
  parameter int ENTRIES   = 128,
  parameter int KEY_CHARS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  krts_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [2:0]     status,
  output logic [6:0]     entry_index,
  output logic [15:0]    copies_out,
  output logic [7:0]     entry_total
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int BW    = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int LW    = $clog2(KEY_CHARS + 1);
  localparam int DEPTH = ENTRIES * KEY_CHARS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_WR, S_SR_RD, S_SR_EV, S_SO_RD, S_SO_EV,
    S_SW_RD, S_SW_WA, S_SW_WB, S_SO_NEXT, S_OUT
  } state_t;

  state_t             state;
  krts_pkg::cmd_kind_t key_kind;
  logic [CW-1:0]      count;
  logic [IW-1:0]      jr;
  logic [IW-1:0]      jr1;
  logic [IW-1:0]      lim;
  logic [BW-1:0]      b;
  logic [7:0]         pend [KEY_CHARS];
  logic [LW-1:0]      plen;
  logic               povf;
  logic [15:0]        cmd_cp;
  logic [2:0]         res_st;
  logic [IW-1:0]      res_idx;
  logic [15:0]        res_cp;
  logic [7:0]         tmp_byte;
  logic [15:0]        tmp_cp;

  logic [7:0]         key_mem [DEPTH];
  logic [15:0]        cp_mem  [ENTRIES];
  logic [7:0]         rda, rdb;
  logic [15:0]        cpa, cpb;

  logic               b_last;
  logic [7:0]         exp_byte;
  logic [AW-1:0]      ra, rb, wa;
  logic [7:0]         wd;
  logic               we;
  logic [IW-1:0]      cp_wa;
  logic [15:0]        cp_wd;
  logic               cp_we;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] rec, input logic [BW-1:0] bi);
    addr = AW'(rec) * AW'(KEY_CHARS) + AW'(bi);
  endfunction

  assign jr1       = jr + 1'b1;
  assign b_last    = (b == BW'(KEY_CHARS - 1));
  assign exp_byte  = (LW'(b) < plen) ? pend[b] : 8'h00;
  assign ra        = addr(jr, b);
  assign rb        = addr(jr1, b);
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    we    = 1'b0;
    wa    = addr(jr, b);
    wd    = rdb;
    cp_we = 1'b0;
    cp_wa = jr;
    cp_wd = cpb;
    unique case (state)
      S_WR: begin
        we    = 1'b1;
        wa    = addr(IW'(count), b);
        wd    = exp_byte;
        cp_we = (b == '0);
        cp_wa = IW'(count);
        cp_wd = cmd_cp;
      end
      S_SW_WA: begin
        we    = 1'b1;
        cp_we = (b == '0);
      end
      S_SW_WB: begin
        we    = 1'b1;
        wa    = addr(jr1, b);
        wd    = tmp_byte;
        cp_we = (b == '0);
        cp_wa = jr1;
        cp_wd = tmp_cp;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) key_mem[wa] <= wd;
    if (cp_we) cp_mem[cp_wa] <= cp_wd;
    rda <= key_mem[ra];
    rdb <= key_mem[rb];
    cpa <= cp_mem[jr];
    cpb <= cp_mem[jr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      plen      <= '0;
      povf      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself when it is taken
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_cp   <= cmd.copies;
            key_kind <= cmd.kind;
            if (cmd.kind == krts_pkg::CMD_SORT) begin
              plen <= '0;
              povf <= 1'b0;
              jr   <= '0;
              b    <= '0;
              lim  <= IW'(count - 1'b1);
              if (count < CW'(2)) begin
                res_st  <= krts_pkg::ST_SORTED;
                res_idx <= '0;
                res_cp  <= '0;
                state   <= S_OUT;
              end else begin
                state <= S_SO_RD;
              end
            end else begin
              if (cmd.ch != 8'h00) begin
                if (plen < LW'(KEY_CHARS)) begin
                  pend[plen[BW-1:0]] <= cmd.ch;
                  plen <= plen + 1'b1;
                end else begin
                  povf <= 1'b1;
                end
              end
              if (cmd.kind != krts_pkg::CMD_CHAR) state <= S_KEY;
            end
          end
        end
        S_KEY: begin
          res_idx <= '0;
          res_cp  <= '0;
          b       <= '0;
          jr      <= '0;
          if (povf) begin
            res_st <= krts_pkg::ST_TOO_LONG;
            plen   <= '0;
            povf   <= 1'b0;
            state  <= S_OUT;
          end else if (key_kind == krts_pkg::CMD_ADD) begin
            if (count < CW'(ENTRIES)) begin
              state <= S_WR;
            end else begin
              res_st <= krts_pkg::ST_FULL;
              plen   <= '0;
              state  <= S_OUT;
            end
          end else if (count == '0) begin
            res_st <= krts_pkg::ST_NOT_FOUND;
            plen   <= '0;
            state  <= S_OUT;
          end else begin
            state <= S_SR_RD;
          end
        end
        S_WR: begin
          if (b_last) begin
            res_st  <= krts_pkg::ST_ADDED;
            res_idx <= IW'(count);
            count   <= count + 1'b1;
            plen    <= '0;
            state   <= S_OUT;
          end else begin
            b <= b + 1'b1;
          end
        end
        S_SR_RD: state <= S_SR_EV;
        S_SR_EV: begin
          if (rda != exp_byte) begin
            if (CW'(jr) + 1'b1 == count) begin
              res_st <= krts_pkg::ST_NOT_FOUND;
              plen   <= '0;
              state  <= S_OUT;
            end else begin
              jr    <= jr1;
              b     <= '0;
              state <= S_SR_RD;
            end
          end else if (b_last) begin
            res_st  <= krts_pkg::ST_FOUND;
            res_idx <= jr;
            res_cp  <= cpa;
            plen    <= '0;
            state   <= S_OUT;
          end else begin
            b     <= b + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_SO_RD: state <= S_SO_EV;
        S_SO_EV: begin
          if (rda != rdb) begin
            if (rda > rdb) begin
              b     <= '0;
              state <= S_SW_RD;
            end else begin
              state <= S_SO_NEXT;
            end
          end else if (b_last) begin
            state <= S_SO_NEXT;
          end else begin
            b     <= b + 1'b1;
            state <= S_SO_RD;
          end
        end
        S_SW_RD: state <= S_SW_WA;
        S_SW_WA: begin
          tmp_byte <= rda;
          if (b == '0) tmp_cp <= cpa;
          state <= S_SW_WB;
        end
        S_SW_WB: begin
          if (b_last) begin
            state <= S_SO_NEXT;
          end else begin
            b     <= b + 1'b1;
            state <= S_SW_RD;
          end
        end
        S_SO_NEXT: begin
          b <= '0;
          // pass ends once the pair whose upper record is at the limit was handled
          if (jr1 < lim) begin
            jr    <= jr1;
            state <= S_SO_RD;
          end else if (lim == IW'(1)) begin
            res_st  <= krts_pkg::ST_SORTED;
            res_idx <= '0;
            res_cp  <= '0;
            state   <= S_OUT;
          end else begin
            lim   <= lim - 1'b1;
            jr    <= '0;
            state <= S_SO_RD;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid   <= 1'b1;
            status      <= res_st;
            entry_index <= 7'(res_idx);
            copies_out  <= res_cp;
            entry_total <= 8'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/keyed_record_table_sort_search_core.sv =====
// Keyed record table with append, linear search and stable bubble sort.
// A character that does not end a key is only added to the pending key. An add
// writes the key into the key store one byte a cycle, padded to KEY_CHARS bytes. A
// search compares the pending key byte by byte with each held record in turn and
// moves on at the first mismatch. A sort takes up to records*(records-1)/2 compares
// of adjacent keys, each byte by byte, and a swap rewrites both records byte by
// byte. A four-entry command queue lets input keep flowing while the back end
// works, and one output register holds the result until it is taken.
module keyed_record_table_sort_search_core #(
  parameter int ENTRIES   = 128,
  parameter int KEY_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mode[1:0], key_char[9:2], copies_in[25:10]
  input  logic        s_axis_tlast,  // key_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[2:0], entry_index[9:3],
                                     // copies_out[25:10], entry_total[33:26]
);

  logic           f_valid, f_ready;
  krts_pkg::cmd_t f_cmd;
  logic           q_valid, q_ready;
  krts_pkg::cmd_t q_cmd;
  logic [2:0]     status;
  logic [6:0]     entry_index;
  logic [15:0]    copies_out;
  logic [7:0]     entry_total;

  krts_front u_front (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  krts_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  krts_back #(.ENTRIES(ENTRIES), .KEY_CHARS(KEY_CHARS)) u_back (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .status, .entry_index, .copies_out, .entry_total
  );

  assign m_axis_tdata = {6'b0, entry_total, copies_out, entry_index, status};

`ifndef ASSERT_OFF
  a_add_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status == krts_pkg::ST_ADDED |-> entry_index == 7'(entry_total - 8'd1))
    else $error("added index does not match record total");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (status == krts_pkg::ST_FULL || status == krts_pkg::ST_NOT_FOUND ||
    status == krts_pkg::ST_SORTED || status == krts_pkg::ST_TOO_LONG)
    |-> entry_index == '0 && copies_out == '0)
    else $error("index or copies nonzero for status without a record");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> entry_total <= 8'(ENTRIES))
    else $error("record total beyond table size");
`endif

endmodule

// ===== test/krts_scoreboard.sv =====
// Checker for the keyed record table: predicts results from input transfers and compares.
module krts_scoreboard #(
  parameter int ENTRIES   = 128,
  parameter int KEY_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count,
  output int          results_owed,
  output int          table_size
);

  typedef struct {
    logic [2:0]  status;
    logic [6:0]  entry_index;
    logic [15:0] copies;
    logic [7:0]  entry_total;
  } table_result_t;

  // byte 0 of a key sits in the top bits so a plain unsigned compare orders like strcmp
  logic [8*KEY_CHARS-1:0] key_mem    [ENTRIES];
  logic [15:0]            copies_mem [ENTRIES];
  int                     held;
  logic [8*KEY_CHARS-1:0] pend_key;
  int                     pend_len;
  bit                     pend_over;
  table_result_t          owed_q[$];

  task automatic report(string field, int got, int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    fail_count++;
  endtask

  task automatic clear_pending();
    pend_key  = '0;
    pend_len  = 0;
    pend_over = 0;
  endtask

  task automatic sort_records();
    logic [8*KEY_CHARS-1:0] tk;
    logic [15:0]            tc;
    for (int i = 0; i + 1 < held; i++)
      for (int j = 0; j + 1 < held - i; j++)
        if (key_mem[j] > key_mem[j+1]) begin
          tk = key_mem[j];    key_mem[j] = key_mem[j+1];       key_mem[j+1] = tk;
          tc = copies_mem[j]; copies_mem[j] = copies_mem[j+1]; copies_mem[j+1] = tc;
        end
  endtask

  task automatic predict_transfer(logic [1:0] mode, logic [7:0] ch, bit last,
                                  logic [15:0] cp);
    table_result_t r;
    bit            done;
    r.status = krts_pkg::ST_SORTED;
    r.entry_index = '0;
    r.copies = '0;
    done = 0;
    if (mode == krts_pkg::MODE_SORT) begin
      clear_pending();
      sort_records();
      done = 1;
    end else if (mode == krts_pkg::MODE_ADD || mode == krts_pkg::MODE_SEARCH) begin
      if (ch != 8'd0) begin
        if (pend_len < KEY_CHARS) begin
          pend_key[8*KEY_CHARS-1-8*pend_len -: 8] = ch;
          pend_len++;
        end else begin
          pend_over = 1;
        end
      end
      if (last) begin
        done = 1;
        if (pend_over) begin
          r.status = krts_pkg::ST_TOO_LONG;
        end else if (mode == krts_pkg::MODE_ADD) begin
          if (held < ENTRIES) begin
            key_mem[held]    = pend_key;
            copies_mem[held] = cp;
            r.status         = krts_pkg::ST_ADDED;
            r.entry_index    = held[6:0];
            held++;
          end else begin
            r.status = krts_pkg::ST_FULL;
          end
        end else begin
          r.status = krts_pkg::ST_NOT_FOUND;
          for (int i = 0; i < held; i++)
            if (r.status == krts_pkg::ST_NOT_FOUND && key_mem[i] == pend_key) begin
              r.status      = krts_pkg::ST_FOUND;
              r.entry_index = i[6:0];
              r.copies      = copies_mem[i];
            end
        end
        clear_pending();
      end
    end
    if (done) begin
      r.entry_total = held[7:0];
      owed_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      held = 0;
      fail_count = 0;
      clear_pending();
      owed_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_transfer(s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tlast,
                         s_axis_tdata[25:10]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata[2:0] != want.status)
            report("status", m_axis_tdata[2:0], want.status);
          if (m_axis_tdata[9:3] != want.entry_index)
            report("entry_index", m_axis_tdata[9:3], want.entry_index);
          if (m_axis_tdata[25:10] != want.copies)
            report("copies_out", m_axis_tdata[25:10], want.copies);
          if (m_axis_tdata[33:26] != want.entry_total)
            report("entry_total", m_axis_tdata[33:26], want.entry_total);
        end
      end
    end
    results_owed = owed_q.size();
    table_size   = held;
  end

endmodule

// ===== test/keyed_record_table_sort_search_core_tb.sv =====
// Testbench top for the keyed record table: stimulus, flow control and verdict.
module keyed_record_table_sort_search_core_tb;

  localparam int ENTRIES      = 128;
  localparam int KEY_CHARS    = 32;
  localparam int TOTAL_ITEMS  = 140;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [1:0] M_ADD  = krts_pkg::MODE_ADD;
  localparam logic [1:0] M_SRCH = krts_pkg::MODE_SEARCH;
  localparam logic [1:0] M_SORT = krts_pkg::MODE_SORT;

  typedef struct {
    logic [8*40-1:0] chars;  // char i at [8i +: 8]
    int              len;
  } key_text_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  int        fail_count;
  int        results_owed;
  int        table_size;
  int        cycles;
  int        sent_items;
  bit        rx_hold_req;
  key_text_t added_keys[$];

  keyed_record_table_sort_search_core #(.ENTRIES(ENTRIES), .KEY_CHARS(KEY_CHARS)) dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  krts_scoreboard #(.ENTRIES(ENTRIES), .KEY_CHARS(KEY_CHARS)) checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count, .results_owed, .table_size
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyed_record_table_sort_search_core regression: fail");
      $finish;
    end
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    m_axis_tready = 0;
    rx_hold_req   = 0;
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        rx_hold_req = 0;
      end else if ($urandom_range(0, 99) < 65) begin
        m_axis_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        m_axis_tready <= 0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  task automatic gap_tx();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 55) begin
      s_axis_tvalid <= 0;
      if (pick >= 95) repeat ($urandom_range(15, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic push_item(logic [1:0] mode, logic [7:0] ch, bit last, logic [15:0] cp);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'd0, cp, ch, mode};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
    gap_tx();
  endtask

  // chars go with body_mode, the final one with last_mode
  task automatic send_key(logic [1:0] body_mode, logic [1:0] last_mode, key_text_t k,
                          logic [15:0] cp);
    if (k.len == 0) push_item(last_mode, 8'd0, 1, cp);
    for (int i = 0; i < k.len; i++)
      push_item((i == k.len - 1) ? last_mode : body_mode, k.chars[8*i +: 8],
                i == k.len - 1, cp);
  endtask

  function automatic key_text_t lit(int len, logic [7:0] c0, logic [7:0] c1 = 0,
                                    logic [7:0] c2 = 0);
    key_text_t k;
    k.chars = '0;
    k.chars[7:0] = c0;
    k.chars[15:8] = c1;
    k.chars[23:16] = c2;
    k.len = len;
    return k;
  endfunction

  // narrow keys share a tiny alphabet so ordering, prefixes and duplicates show up
  function automatic key_text_t make_key(int len, bit wide);
    key_text_t k;
    k.chars = '0;
    k.len = len;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) k.chars[8*i +: 8] = 8'd0;
      else if (wide) k.chars[8*i +: 8] = $urandom_range(1, 255);
      else k.chars[8*i +: 8] = $urandom_range(97, 99);
    end
    return k;
  endfunction

  function automatic key_text_t pick_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return make_key(KEY_CHARS, 1);
    if (pick < 30) return make_key($urandom_range(1, 6), 1);
    return make_key($urandom_range(1, 4), 0);
  endfunction

  // the first edge lets the checker count the last accepted transfer
  task automatic wait_drained();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    key_text_t k;
    int        pick;
    rst           = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 0;
    sent_items    = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    push_item(M_SORT, 8'hFF, 1, 16'hFFFF);                     // sort of an empty table
    send_key(M_ADD, M_ADD, lit(1, 8'hFF), 16'hFFFF);
    send_key(M_ADD, M_ADD, lit(2, 8'h01, "b"), 16'h0000);
    send_key(M_ADD, M_ADD, lit(0, 0), 16'h1234);               // empty key
    send_key(M_ADD, M_ADD, lit(3, "a", 8'h00, "z"), 16'h5A5A);
    send_key(M_SRCH, M_SRCH, lit(2, 8'h01, "b"), 16'hA5A5);
    send_key(M_SRCH, M_SRCH, lit(1, "b"), 16'h0);
    push_item(MODE_IGNORED, 8'h55, 1, 16'hFFFF);
    send_key(M_ADD, M_SRCH, lit(2, "q", "r"), 16'h0);          // add chars, search end
    send_key(M_ADD, M_SRCH, lit(2, "a", "z"), 16'h0);
    send_key(M_SRCH, M_ADD, lit(2, "m", "n"), 16'h8001);
    push_item(M_SORT, 8'h00, 0, 16'h0);
    send_key(M_SRCH, M_SRCH, lit(0, 0), 16'h0);
    send_key(M_SRCH, M_SRCH, lit(1, 8'hFF), 16'h0);
    push_item(M_ADD, "x", 0, 16'h0);                           // key in progress, then sort
    push_item(M_SORT, 8'h00, 0, 16'h0);
    send_key(M_SRCH, M_SRCH, lit(1, "x"), 16'h0);

    // sender waits out every result, then the receiver holds off while input piles up
    s_axis_tvalid <= 0;
    wait_drained();
    rx_hold_req = 1;

    while (sent_items < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        k = pick_key();
        send_key(M_ADD, M_ADD, k, $urandom);
        added_keys.push_back(k);
      end else if (pick < 68) begin
        if (added_keys.size() > 0 && $urandom_range(0, 9) < 7)
          k = added_keys[$urandom_range(0, added_keys.size() - 1)];
        else
          k = pick_key();
        send_key(M_SRCH, M_SRCH, k, $urandom);
      end else if (pick < 76) begin
        if (table_size <= 20) push_item(M_SORT, $urandom, $urandom, $urandom);
        else send_key(M_SRCH, M_SRCH, pick_key(), $urandom);
      end else if (pick < 81) begin
        push_item(MODE_IGNORED, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        k = pick_key();
        if ($urandom_range(0, 1)) send_key(M_ADD, M_SRCH, k, $urandom);
        else send_key(M_SRCH, M_ADD, k, $urandom);
      end else if (pick < 95) begin
        k = pick_key();
        for (int i = 0; i < k.len; i++)
          push_item($urandom_range(0, 1) ? M_ADD : M_SRCH, k.chars[8*i +: 8], 0,
                    $urandom);
        if (table_size <= 20) push_item(M_SORT, $urandom, $urandom, $urandom);
      end else begin
        k = make_key($urandom_range(KEY_CHARS + 1, KEY_CHARS + 4), 1);
        send_key(M_ADD, $urandom_range(0, 1) ? M_ADD : M_SRCH, k, $urandom);
      end
    end

    s_axis_tvalid <= 0;
    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("keyed_record_table_sort_search_core regression: pass");
    else
      $display("keyed_record_table_sort_search_core regression: fail");
    $finish;
  end

endmodule
